// ----- hw/rtl/mesh_task_placer_nearest_free_assert.svh -----
// Assertion macros for the nearest-free task placer.
// Each macro takes a label, an antecedent and a consequent, sampled on clock
// and switched off while reset is high.
`ifndef MESH_TASK_PLACER_NEAREST_FREE_ASSERT_SVH
`define MESH_TASK_PLACER_NEAREST_FREE_ASSERT_SVH
`ifndef SYNTH
`define MTP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mtp: same-cycle check failed");
`define MTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtp: next-cycle check failed");
`else
`define MTP_ASSERT_NOW(label, ante, cons)
`define MTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/mtp_pkg.sv -----
package mtp_pkg;

   // Mesh geometry and table sizes.
   localparam int MESH_X    = 8;
   localparam int PE_COUNT  = 64;
   localparam int MAX_TASKS = 64;

   // Field width of every PE or task number in a word.
   localparam int FIELD_W  = 6;
   localparam int EXT_W    = FIELD_W + 1;
   localparam int PE_IDX_W = $clog2(PE_COUNT);
   localparam int TASK_W   = $clog2(MAX_TASKS);
   localparam int HOP_W    = FIELD_W + 1;

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PLACE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_PLACED        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE       = 2'd1;
   localparam logic [1:0] STATUS_PRED_UNPLACED = 2'd2;
   localparam logic [1:0] STATUS_START_BUSY    = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_FINISH
   } mtp_state_type;

   typedef struct packed {
      logic               req_type;
      logic [FIELD_W-1:0] task_id;
      logic [FIELD_W-1:0] pred_task;
      logic [FIELD_W-1:0] start_node;
   } mtp_req_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0] placed_pe;
      logic [1:0]         status;
   } mtp_rsp_word_type;

   // Controls from the sequencer to the distance unit.
   typedef struct packed {
      logic               clear;
      logic               step;
      logic [FIELD_W-1:0] pe;
      logic               pe_free;
      logic [FIELD_W-1:0] from_pe;
      logic [FIELD_W-1:0] anchor_pe;
   } mtp_scan_ctrl_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] best_pe;
   } mtp_scan_result_type;

   // Controls from the sequencer to the task table.
   typedef struct packed {
      logic              rd_en;
      logic [TASK_W-1:0] rd_addr;
      logic              wr_en;
      logic [TASK_W-1:0] wr_addr;
      logic [FIELD_W-1:0] wr_data;
      logic              clear_all;
   } mtp_table_ctrl_type;

   // Row and column of a PE in the mesh.
   function automatic logic [FIELD_W-1:0] pe_row(input logic [FIELD_W-1:0] pe);
      return FIELD_W'(pe / MESH_X);
   endfunction

   function automatic logic [FIELD_W-1:0] pe_col(input logic [FIELD_W-1:0] pe);
      return FIELD_W'(pe % MESH_X);
   endfunction

   function automatic logic [FIELD_W-1:0] abs_diff(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- hw/rtl/mtp_task_table.sv -----
module mtp_task_table (
   input  logic                          clock,
   input  logic                          reset,
   input  mtp_pkg::mtp_table_ctrl_type   table_ctrl,
   output logic [mtp_pkg::FIELD_W-1:0]   rd_loc,
   output logic                          rd_placed
);

   // PE of each task; only used where the placed bit is set.
   logic [mtp_pkg::FIELD_W-1:0]   loc_mem_ff [mtp_pkg::MAX_TASKS];
   logic [mtp_pkg::MAX_TASKS-1:0] placed_ff;
   logic [mtp_pkg::MAX_TASKS-1:0] placed_in;
   logic [mtp_pkg::FIELD_W-1:0]   rd_loc_ff;
   logic                          rd_placed_ff;

   // A start clears the whole table before its own task is recorded.
   always_comb begin
      placed_in = placed_ff;
      if (table_ctrl.clear_all) begin
         placed_in = '0;
      end
      if (table_ctrl.wr_en) begin
         placed_in[table_ctrl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         placed_ff <= '0;
      end else begin
         placed_ff <= placed_in;
      end
   end

   // Location memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (table_ctrl.wr_en) begin
         loc_mem_ff[table_ctrl.wr_addr] <= table_ctrl.wr_data;
      end
      if (table_ctrl.rd_en) begin
         rd_loc_ff    <= loc_mem_ff[table_ctrl.rd_addr];
         rd_placed_ff <= placed_ff[table_ctrl.rd_addr];
      end
   end

   assign rd_loc    = rd_loc_ff;
   assign rd_placed = rd_placed_ff;

endmodule

// ----- hw/rtl/mtp_scan_unit.sv -----
module mtp_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  mtp_pkg::mtp_scan_ctrl_type    scan_ctrl,
   output mtp_pkg::mtp_scan_result_type  scan_result
);

   logic                        found_ff;
   logic                        found_in;
   logic [mtp_pkg::FIELD_W-1:0] best_pe_ff;
   logic [mtp_pkg::HOP_W-1:0]   best_hop_ff;
   logic [mtp_pkg::FIELD_W-1:0] best_cheb_ff;
   logic [mtp_pkg::HOP_W-1:0]   hop;
   logic [mtp_pkg::FIELD_W-1:0] cheb;
   logic [mtp_pkg::FIELD_W-1:0] anchor_dy;
   logic [mtp_pkg::FIELD_W-1:0] anchor_dx;
   logic                        better;
   logic                        take;

   // Distances of the candidate PE: hops from the predecessor, Chebyshev
   // distance from the anchor node.
   always_comb begin
      hop = mtp_pkg::HOP_W'(mtp_pkg::abs_diff(mtp_pkg::pe_row(scan_ctrl.from_pe),
                                              mtp_pkg::pe_row(scan_ctrl.pe)))
          + mtp_pkg::HOP_W'(mtp_pkg::abs_diff(mtp_pkg::pe_col(scan_ctrl.from_pe),
                                              mtp_pkg::pe_col(scan_ctrl.pe)));
      anchor_dy = mtp_pkg::abs_diff(mtp_pkg::pe_row(scan_ctrl.pe),
                                    mtp_pkg::pe_row(scan_ctrl.anchor_pe));
      anchor_dx = mtp_pkg::abs_diff(mtp_pkg::pe_col(scan_ctrl.pe),
                                    mtp_pkg::pe_col(scan_ctrl.anchor_pe));
      cheb = (anchor_dy > anchor_dx) ? anchor_dy : anchor_dx;
   end

   // Strictly better only, so ties keep the lower PE seen first.
   always_comb begin
      better = !found_ff || (hop < best_hop_ff)
             || ((hop == best_hop_ff) && (cheb < best_cheb_ff));
      take   = scan_ctrl.step && scan_ctrl.pe_free && better;
      found_in = found_ff;
      if (scan_ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // Best candidate so far.
   always_ff @(posedge clock) begin
      if (take && !scan_ctrl.clear) begin
         best_pe_ff   <= scan_ctrl.pe;
         best_hop_ff  <= hop;
         best_cheb_ff <= cheb;
      end
   end

   assign scan_result.found   = found_ff;
   assign scan_result.best_pe = best_pe_ff;

endmodule

// ----- hw/rtl/mesh_task_placer_nearest_free.sv -----
// Results: a start word, or a place word whose predecessor is unplaced, gives its
// result from the decide state; a place word that scans gives it from the finish
// state, after the scan state has stepped through PEs 1 to PE_COUNT - 1.
// Throughput: one word at a time, busy until its result is given; the distance
// unit visits one PE per cycle while scanning. The receiver cannot stall.
// Reset (synchronous): PE 0 busy, all other PEs free, no task placed, anchor zero.
`include "mesh_task_placer_nearest_free_assert.svh"

module mesh_task_placer_nearest_free (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mtp_pkg::mtp_req_word_type  req_word,
   output logic                       rsp_strobe,
   output mtp_pkg::mtp_rsp_word_type  rsp_word
);

   localparam logic [mtp_pkg::PE_IDX_W-1:0] PE_LAST =
      mtp_pkg::PE_IDX_W'(mtp_pkg::PE_COUNT - 1);

   mtp_pkg::mtp_state_type       state_ff, state_in;
   mtp_pkg::mtp_req_word_type    req_ff, req_in;
   logic [mtp_pkg::PE_COUNT-1:0] busy_map_ff, busy_map_in;
   logic [mtp_pkg::FIELD_W-1:0]  anchor_ff, anchor_in;
   logic [mtp_pkg::FIELD_W-1:0]  from_ff, from_in;
   logic [mtp_pkg::PE_IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   mtp_pkg::mtp_rsp_word_type    rsp_word_ff, rsp_word_in;

   mtp_pkg::mtp_table_ctrl_type  table_ctrl;
   mtp_pkg::mtp_scan_ctrl_type   scan_ctrl;
   mtp_pkg::mtp_scan_result_type scan_result;
   logic [mtp_pkg::FIELD_W-1:0]  rd_loc;
   logic                         rd_placed;

   logic accept;
   logic task_ok;
   logic pred_ok;
   logic start_bad;

   mtp_task_table u_table (
      .clock      (clock),
      .reset      (reset),
      .table_ctrl (table_ctrl),
      .rd_loc     (rd_loc),
      .rd_placed  (rd_placed)
   );

   mtp_scan_unit u_scan (
      .clock       (clock),
      .reset       (reset),
      .scan_ctrl   (scan_ctrl),
      .scan_result (scan_result)
   );

   assign busy   = (state_ff != mtp_pkg::S_IDLE);
   assign accept = start && !busy;

   // Range and occupancy checks on the held word.
   always_comb begin
      task_ok = (mtp_pkg::EXT_W'(req_ff.task_id) < mtp_pkg::EXT_W'(mtp_pkg::MAX_TASKS));
      pred_ok = (mtp_pkg::EXT_W'(req_ff.pred_task) < mtp_pkg::EXT_W'(mtp_pkg::MAX_TASKS))
              && rd_placed;
      start_bad = (mtp_pkg::EXT_W'(req_ff.start_node)
                   >= mtp_pkg::EXT_W'(mtp_pkg::PE_COUNT))
                || (req_ff.start_node == '0)
                || busy_map_ff[req_ff.start_node[mtp_pkg::PE_IDX_W-1:0]];
   end

   // Sequencer: next state, table and distance unit controls, result word.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      busy_map_in   = busy_map_ff;
      anchor_in     = anchor_ff;
      from_in       = from_ff;
      scan_idx_in   = scan_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      table_ctrl.rd_en     = 1'b0;
      table_ctrl.rd_addr   = req_word.pred_task[mtp_pkg::TASK_W-1:0];
      table_ctrl.wr_en     = 1'b0;
      table_ctrl.wr_addr   = req_ff.task_id[mtp_pkg::TASK_W-1:0];
      table_ctrl.wr_data   = req_ff.start_node;
      table_ctrl.clear_all = 1'b0;

      scan_ctrl.clear     = 1'b0;
      scan_ctrl.step      = 1'b0;
      scan_ctrl.pe        = mtp_pkg::FIELD_W'(scan_idx_ff);
      scan_ctrl.pe_free   = !busy_map_ff[scan_idx_ff];
      scan_ctrl.from_pe   = from_ff;
      scan_ctrl.anchor_pe = anchor_ff;

      case (state_ff)
         mtp_pkg::S_IDLE: begin
            // Look up the predecessor while the word is taken in.
            if (accept) begin
               table_ctrl.rd_en = 1'b1;
               req_in           = req_word;
               state_in         = mtp_pkg::S_DECIDE;
            end
         end
         mtp_pkg::S_DECIDE: begin
            if (req_ff.req_type == mtp_pkg::REQ_START) begin
               rsp_strobe_in = 1'b1;
               state_in      = mtp_pkg::S_IDLE;
               if (start_bad) begin
                  rsp_word_in.placed_pe = '0;
                  rsp_word_in.status    = mtp_pkg::STATUS_START_BUSY;
               end else begin
                  busy_map_in[req_ff.start_node[mtp_pkg::PE_IDX_W-1:0]] = 1'b1;
                  anchor_in              = req_ff.start_node;
                  table_ctrl.clear_all   = 1'b1;
                  table_ctrl.wr_en       = task_ok;
                  rsp_word_in.placed_pe  = req_ff.start_node;
                  rsp_word_in.status     = mtp_pkg::STATUS_PLACED;
               end
            end else if (!pred_ok) begin
               rsp_strobe_in         = 1'b1;
               rsp_word_in.placed_pe = '0;
               rsp_word_in.status    = mtp_pkg::STATUS_PRED_UNPLACED;
               state_in              = mtp_pkg::S_IDLE;
            end else begin
               // PE 0 is reserved, so the scan starts at PE 1.
               from_in         = rd_loc;
               scan_ctrl.clear = 1'b1;
               scan_idx_in     = mtp_pkg::PE_IDX_W'(1);
               state_in        = mtp_pkg::S_SCAN;
            end
         end
         mtp_pkg::S_SCAN: begin
            // One PE through the distance unit each cycle.
            scan_ctrl.step = 1'b1;
            if (scan_idx_ff == PE_LAST) begin
               state_in = mtp_pkg::S_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         mtp_pkg::S_FINISH: begin
            rsp_strobe_in = 1'b1;
            state_in      = mtp_pkg::S_IDLE;
            if (scan_result.found) begin
               busy_map_in[scan_result.best_pe[mtp_pkg::PE_IDX_W-1:0]] = 1'b1;
               table_ctrl.wr_en      = task_ok;
               table_ctrl.wr_data    = scan_result.best_pe;
               rsp_word_in.placed_pe = scan_result.best_pe;
               rsp_word_in.status    = mtp_pkg::STATUS_PLACED;
            end else begin
               rsp_word_in.placed_pe = '0;
               rsp_word_in.status    = mtp_pkg::STATUS_NO_FREE;
            end
         end
         default: begin
            state_in = mtp_pkg::S_IDLE;
         end
      endcase
   end

   // Control state and the PE occupancy map.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtp_pkg::S_IDLE;
         busy_map_ff   <= mtp_pkg::PE_COUNT'(1);
         anchor_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_map_ff   <= busy_map_in;
         anchor_ff     <= anchor_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Held request, scan position and result word.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      from_ff     <= from_in;
      scan_idx_ff <= scan_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // A result appears only once the block is free again.
   `MTP_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy)
   // An accepted word keeps the block busy in the next cycle.
   `MTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // PE 0 is reserved and is never handed out.
   `MTP_ASSERT_NOW(a_placed_nonzero, rsp_strobe && (rsp_word.status == mtp_pkg::STATUS_PLACED), rsp_word.placed_pe != '0)
   // Every error result reports PE zero.
   `MTP_ASSERT_NOW(a_error_zero, rsp_strobe && (rsp_word.status != mtp_pkg::STATUS_PLACED), rsp_word.placed_pe == '0)

endmodule

// ----- tb/sv/mesh_task_placer_nearest_free_test.sv -----
`timescale 1ns / 1ps

module mesh_task_placer_nearest_free_test;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_WORDS  = 1800;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = mtp_pkg::PE_COUNT + 8;

   // Whether a directed row carries its own expected result or leaves it to the predictor.
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   typedef struct packed {
      logic                        kind;
      logic [mtp_pkg::FIELD_W-1:0] task_no;
      logic [mtp_pkg::FIELD_W-1:0] pred_no;
      logic [mtp_pkg::FIELD_W-1:0] node;
      logic                        typed;
      logic [mtp_pkg::FIELD_W-1:0] want_pe;
      logic [1:0]                  want_status;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // Directed words: reserved PE, busy start, unplaced predecessor, a task placed twice,
   // table clearing on start, a failed start that keeps the table, and the field extremes.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{mtp_pkg::REQ_PLACE, 6'd5,  6'd0,  6'd0,  TYPED,     6'd0,  mtp_pkg::STATUS_PRED_UNPLACED},
      '{mtp_pkg::REQ_START, 6'd0,  6'd63, 6'd0,  TYPED,     6'd0,  mtp_pkg::STATUS_START_BUSY},
      '{mtp_pkg::REQ_START, 6'd63, 6'd0,  6'd63, TYPED,     6'd63, mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_START, 6'd1,  6'd0,  6'd63, TYPED,     6'd0,  mtp_pkg::STATUS_START_BUSY},
      '{mtp_pkg::REQ_PLACE, 6'd0,  6'd63, 6'd63, PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd62, 6'd0,  6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd1,  6'd62, 6'd21, PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd2,  6'd40, 6'd0,  TYPED,     6'd0,  mtp_pkg::STATUS_PRED_UNPLACED},
      '{mtp_pkg::REQ_PLACE, 6'd0,  6'd0,  6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd9,  6'd0,  6'd42, PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_START, 6'd10, 6'd63, 6'd1,  TYPED,     6'd1,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd11, 6'd63, 6'd0,  TYPED,     6'd0,  mtp_pkg::STATUS_PRED_UNPLACED},
      '{mtp_pkg::REQ_PLACE, 6'd63, 6'd10, 6'd63, PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd0,  6'd63, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_START, 6'd20, 6'd0,  6'd36, TYPED,     6'd36, mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd21, 6'd20, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd22, 6'd20, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd23, 6'd20, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd24, 6'd20, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd25, 6'd21, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd42, 6'd25, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_START, 6'd30, 6'd0,  6'd36, TYPED,     6'd0,  mtp_pkg::STATUS_START_BUSY},
      '{mtp_pkg::REQ_PLACE, 6'd31, 6'd42, 6'd0,  PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_START, 6'd0,  6'd0,  6'd7,  TYPED,     6'd7,  mtp_pkg::STATUS_PLACED},
      '{mtp_pkg::REQ_PLACE, 6'd63, 6'd0,  6'd63, PREDICTED, 6'd0,  mtp_pkg::STATUS_PLACED}
   };

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   mtp_pkg::mtp_req_word_type req_word;
   logic                      rsp_strobe;
   mtp_pkg::mtp_rsp_word_type rsp_word;

   // Predictor state: which PEs are taken, where each task sits, and the anchor.
   bit [mtp_pkg::PE_COUNT-1:0]  pe_taken;
   logic [mtp_pkg::FIELD_W-1:0] task_home [mtp_pkg::MAX_TASKS];
   bit [mtp_pkg::MAX_TASKS-1:0] task_known;
   logic [mtp_pkg::FIELD_W-1:0] anchor_pe;

   // Expected results by word number; words_sent moves with a nonblocking update so the
   // checker never sees an entry that is being written in the same step.
   mtp_pkg::mtp_rsp_word_type expected_by_seq [RANDOM_WORDS + DIRECTED_COUNT + 16];
   int words_sent   = 0;
   int results_seen = 0;
   int error_count  = 0;
   int cycle_count  = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   mesh_task_placer_nearest_free DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // Applies one word to the predicted mesh and returns the result it should give.
   function automatic mtp_pkg::mtp_rsp_word_type predict_placement(
      input mtp_pkg::mtp_req_word_type w);
      mtp_pkg::mtp_rsp_word_type r;
      int from_row, from_col, anchor_row, anchor_col;
      int dr, dc, hop, cheb, best_hop, best_cheb;
      bit found;
      logic [mtp_pkg::FIELD_W-1:0] best;
      r.placed_pe = '0;
      r.status    = mtp_pkg::STATUS_PLACED;
      if (w.req_type == mtp_pkg::REQ_START) begin
         if (w.start_node >= mtp_pkg::PE_COUNT || w.start_node == 0
             || pe_taken[w.start_node]) begin
            r.status = mtp_pkg::STATUS_START_BUSY;
         end else begin
            task_known = '0;
            pe_taken[w.start_node] = 1'b1;
            anchor_pe = w.start_node;
            if (w.task_id < mtp_pkg::MAX_TASKS) begin
               task_home[w.task_id]  = w.start_node;
               task_known[w.task_id] = 1'b1;
            end
            r.placed_pe = w.start_node;
         end
         return r;
      end
      if (w.pred_task >= mtp_pkg::MAX_TASKS || !task_known[w.pred_task]) begin
         r.status = mtp_pkg::STATUS_PRED_UNPLACED;
         return r;
      end

      // Scan the free PEs for the least hop count, then the least ring around the anchor.
      from_row   = int'(task_home[w.pred_task]) / mtp_pkg::MESH_X;
      from_col   = int'(task_home[w.pred_task]) % mtp_pkg::MESH_X;
      anchor_row = int'(anchor_pe) / mtp_pkg::MESH_X;
      anchor_col = int'(anchor_pe) % mtp_pkg::MESH_X;
      found      = 1'b0;
      best       = '0;
      best_hop   = 0;
      best_cheb  = 0;
      for (int p = 1; p < mtp_pkg::PE_COUNT; p++) begin
         if (!pe_taken[p]) begin
            dr   = (p / mtp_pkg::MESH_X > from_row) ? p / mtp_pkg::MESH_X - from_row
                                                    : from_row - p / mtp_pkg::MESH_X;
            dc   = (p % mtp_pkg::MESH_X > from_col) ? p % mtp_pkg::MESH_X - from_col
                                                    : from_col - p % mtp_pkg::MESH_X;
            hop  = dr + dc;
            dr   = (p / mtp_pkg::MESH_X > anchor_row) ? p / mtp_pkg::MESH_X - anchor_row
                                                      : anchor_row - p / mtp_pkg::MESH_X;
            dc   = (p % mtp_pkg::MESH_X > anchor_col) ? p % mtp_pkg::MESH_X - anchor_col
                                                      : anchor_col - p % mtp_pkg::MESH_X;
            cheb = (dr > dc) ? dr : dc;
            if (!found || hop < best_hop || (hop == best_hop && cheb < best_cheb)) begin
               found     = 1'b1;
               best      = mtp_pkg::FIELD_W'(p);
               best_hop  = hop;
               best_cheb = cheb;
            end
         end
      end
      if (!found) begin
         r.status = mtp_pkg::STATUS_NO_FREE;
         return r;
      end
      pe_taken[best] = 1'b1;
      if (w.task_id < mtp_pkg::MAX_TASKS) begin
         task_home[w.task_id]  = best;
         task_known[w.task_id] = 1'b1;
      end
      r.placed_pe = best;
      return r;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want_val);
      error_count++;
      $display("[%0t] result %0d: %s is %0d, expected %0d",
               $realtime, results_seen, what, got, want_val);
   endtask

   // Offers one word and holds it until the block takes it, then records the expectation.
   // Start stays high so that a following word can go out without a gap.
   task automatic offer_word(input mtp_pkg::mtp_req_word_type w, input logic typed,
                             input mtp_pkg::mtp_rsp_word_type typed_rsp);
      mtp_pkg::mtp_rsp_word_type want;
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      want = predict_placement(w);
      if (typed)
         want = typed_rsp;
      expected_by_seq[words_sent] = want;
      words_sent <= words_sent + 1;
   endtask

   // Lowers start and waits until every outstanding word has given its result.
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (results_seen != words_sent);
      @(posedge clock);
   endtask

   // Stimulus: reset, the directed table, then random words.
   initial begin
      mtp_pkg::mtp_req_word_type w;
      mtp_pkg::mtp_rsp_word_type typed_rsp;
      int roll;
      int free_pes [mtp_pkg::PE_COUNT];
      int free_count;
      int known_tasks [mtp_pkg::MAX_TASKS];
      int known_count;
      int gap;

      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      pe_taken   = '0;
      pe_taken[0] = 1'b1;
      task_known = '0;
      anchor_pe  = '0;
      foreach (task_home[n])
         task_home[n] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, one row per word.
      foreach (DIRECTED_ROWS[r]) begin
         w.req_type   = DIRECTED_ROWS[r].kind;
         w.task_id    = DIRECTED_ROWS[r].task_no;
         w.pred_task  = DIRECTED_ROWS[r].pred_no;
         w.start_node = DIRECTED_ROWS[r].node;
         typed_rsp.placed_pe = DIRECTED_ROWS[r].want_pe;
         typed_rsp.status    = DIRECTED_ROWS[r].want_status;
         offer_word(w, DIRECTED_ROWS[r].typed, typed_rsp);
      end
      drain_results();

      // Random part: mostly starts on free PEs and placements after placed tasks.
      typed_rsp = '0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         free_count  = 0;
         known_count = 0;
         for (int n = 1; n < mtp_pkg::PE_COUNT; n++)
            if (!pe_taken[n]) begin
               free_pes[free_count] = n;
               free_count++;
            end
         for (int n = 0; n < mtp_pkg::MAX_TASKS; n++)
            if (task_known[n]) begin
               known_tasks[known_count] = n;
               known_count++;
            end

         roll = $urandom_range(0, 99);
         w.task_id    = mtp_pkg::FIELD_W'($urandom_range(0, 63));
         w.pred_task  = mtp_pkg::FIELD_W'($urandom_range(0, 63));
         w.start_node = mtp_pkg::FIELD_W'($urandom_range(0, 63));
         if (roll < 8) begin
            w.req_type = mtp_pkg::REQ_START;
            if (roll < 5 && free_count > 0)
               w.start_node = mtp_pkg::FIELD_W'(free_pes[$urandom_range(0, free_count - 1)]);
         end else begin
            w.req_type = mtp_pkg::REQ_PLACE;
            if (roll < 90 && known_count > 0)
               w.pred_task =
                  mtp_pkg::FIELD_W'(known_tasks[$urandom_range(0, known_count - 1)]);
         end
         offer_word(w, PREDICTED, typed_rsp);

         // Sender gaps, counted from the moment the block is free again so that each
         // one leaves the handshake idle.
         if (i == RANDOM_WORDS / 2) begin
            drain_results();
         end else if ((i < 700 || i >= 1000) && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 100);
            start <= 1'b0;
            do @(posedge clock); while (busy !== 1'b0);
            repeat (gap) @(posedge clock);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d words, %0d of them directed, through placement up to a full mesh.",
               words_sent, DIRECTED_COUNT);
      $display("Results: %0d placed, %0d no free PE, %0d predecessor unplaced, %0d start busy.",
               status_seen[mtp_pkg::STATUS_PLACED], status_seen[mtp_pkg::STATUS_NO_FREE],
               status_seen[mtp_pkg::STATUS_PRED_UNPLACED],
               status_seen[mtp_pkg::STATUS_START_BUSY]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result checker: each strobed word is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      mtp_pkg::mtp_rsp_word_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (results_seen >= words_sent) begin
            report_mismatch("result with nothing outstanding, placed_pe",
                            int'(rsp_word.placed_pe), -1);
         end else begin
            want = expected_by_seq[results_seen];
            if (rsp_word.placed_pe !== want.placed_pe)
               report_mismatch("placed_pe", int'(rsp_word.placed_pe), int'(want.placed_pe));
            if (rsp_word.status !== want.status)
               report_mismatch("status", int'(rsp_word.status), int'(want.status));
            status_seen[want.status]++;
            results_seen++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d of %0d results seen.",
                  cycle_count, results_seen, words_sent);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_task_table.sv
hw/rtl/mtp_scan_unit.sv
hw/rtl/mesh_task_placer_nearest_free.sv
tb/sv/mesh_task_placer_nearest_free_test.sv
